// ===== design/dpau_pkg.sv =====
// Shared types and constants for the dual pulse audio unit.
// Holds the action codes, register offsets, duty and length tables.
// No dependencies.
package dpau_pkg;

  typedef enum logic [1:0] {
    ACT_TICK  = 2'd0,
    ACT_WRITE = 2'd1,
    ACT_READ  = 2'd2,
    ACT_NONE  = 2'd3
  } dpau_action_t;

  // Per-channel register select, low two offset bits
  localparam logic [1:0] OFF_CH_CTRL = 2'd0;
  localparam logic [1:0] OFF_CH_LO   = 2'd2;
  localparam logic [1:0] OFF_CH_HI   = 2'd3;

  localparam logic [4:0] OFF_PCM    = 5'h11;
  localparam logic [4:0] OFF_STATUS = 5'h15;

  localparam logic [12:0] QUARTER_LAST = 13'd7456;
  localparam logic [13:0] HALF_LAST    = 14'd14912;

  localparam logic [15:0] MIX_PULSE = 16'd493;
  localparam logic [15:0] MIX_PCM   = 16'd131;

  localparam logic [7:0] DUTY_BITS [4] = '{8'h02, 8'h06, 8'h1E, 8'hF9};

  localparam logic [7:0] LENGTH_LOAD [32] = '{
    8'd10,  8'd254, 8'd20, 8'd2,  8'd40, 8'd4,  8'd80, 8'd6,
    8'd160, 8'd8,   8'd60, 8'd10, 8'd14, 8'd12, 8'd26, 8'd14,
    8'd12,  8'd16,  8'd24, 8'd18, 8'd48, 8'd20, 8'd96, 8'd22,
    8'd192, 8'd24,  8'd72, 8'd26, 8'd16, 8'd28, 8'd32, 8'd30
  };

  // Strobes from the bus decoder into one pulse channel
  typedef struct packed {
    logic tick;
    logic env_clk;
    logic len_clk;
    logic wr_ctrl;
    logic wr_lo;
    logic wr_hi;
    logic wr_enable;
    logic enable_bit;
  } dpau_ch_ctl_t;

endpackage

// ===== design/dpau_pulse_channel.sv =====
// One square pulse channel: timer, duty sequencer, envelope and length counter.
// Gives the level after the current item is applied.
// Depends on dpau_pkg.
module dpau_pulse_channel (
  input  logic                 clk,
  input  logic                 rst,
  input  dpau_pkg::dpau_ch_ctl_t ctl,
  input  logic [7:0]           wdata,
  output logic [3:0]           level,
  output logic                 len_active
);
  import dpau_pkg::*;

  logic [11:0] timer, timer_next;
  logic [10:0] period, period_next;
  logic [2:0]  step, step_next;
  logic [1:0]  duty, duty_next;
  logic        halt, halt_next;
  logic        const_vol, const_vol_next;
  logic [3:0]  vol, vol_next;
  logic        restart, restart_next;
  logic [3:0]  env_level, env_level_next;
  logic [3:0]  env_count, env_count_next;
  logic [7:0]  length, length_next;
  logic        enabled, enabled_next;
  logic [7:0]  duty_pattern;

  always_comb begin
    timer_next     = timer;
    period_next    = period;
    step_next      = step;
    duty_next      = duty;
    halt_next      = halt;
    const_vol_next = const_vol;
    vol_next       = vol;
    restart_next   = restart;
    env_level_next = env_level;
    env_count_next = env_count;
    length_next    = length;
    enabled_next   = enabled;

    if (ctl.tick) begin
      if (timer == 12'd0) begin
        timer_next = {period, 1'b1};
        step_next  = step + 3'd1;
      end else begin
        timer_next = timer - 12'd1;
      end
    end

    if (ctl.env_clk) begin
      if (restart) begin
        restart_next   = 1'b0;
        env_level_next = 4'hF;
        env_count_next = vol;
      end else if (env_count == 4'd0) begin
        env_count_next = vol;
        if (env_level != 4'd0) begin
          env_level_next = env_level - 4'd1;
        end else if (halt) begin
          env_level_next = 4'hF;
        end
      end else begin
        env_count_next = env_count - 4'd1;
      end
    end

    if (ctl.len_clk && length != 8'd0 && !halt) begin
      length_next = length - 8'd1;
    end

    if (ctl.wr_ctrl) begin
      duty_next      = wdata[7:6];
      halt_next      = wdata[5];
      const_vol_next = wdata[4];
      vol_next       = wdata[3:0];
    end

    if (ctl.wr_lo) begin
      period_next[7:0] = wdata;
    end

    if (ctl.wr_hi) begin
      period_next[10:8] = wdata[2:0];
      if (enabled) begin
        length_next = LENGTH_LOAD[wdata[7:3]];
      end
      step_next    = 3'd0;
      restart_next = 1'b1;
    end

    if (ctl.wr_enable) begin
      enabled_next = ctl.enable_bit;
      if (!ctl.enable_bit) begin
        length_next = 8'd0;
      end
    end
  end

  // Level as seen after this item
  always_comb begin
    duty_pattern = DUTY_BITS[duty_next];
    if (!enabled_next || length_next == 8'd0 || period_next[10:3] == 8'd0 ||
        !duty_pattern[step_next]) begin
      level = 4'd0;
    end else if (const_vol_next) begin
      level = vol_next;
    end else begin
      level = env_level_next;
    end
  end

  assign len_active = (length_next != 8'd0);

  always_ff @(posedge clk) begin
    if (rst) begin
      timer     <= '0;
      period    <= '0;
      step      <= '0;
      duty      <= '0;
      halt      <= 1'b0;
      const_vol <= 1'b0;
      vol       <= '0;
      restart   <= 1'b0;
      env_level <= '0;
      env_count <= '0;
      length    <= '0;
      enabled   <= 1'b0;
    end else begin
      timer     <= timer_next;
      period    <= period_next;
      step      <= step_next;
      duty      <= duty_next;
      halt      <= halt_next;
      const_vol <= const_vol_next;
      vol       <= vol_next;
      restart   <= restart_next;
      env_level <= env_level_next;
      env_count <= env_count_next;
      length    <= length_next;
      enabled   <= enabled_next;
    end
  end

endmodule

// ===== design/dual_pulse_audio_unit.sv =====
// Top level of the dual pulse audio unit: bus decode, frame dividers, mixer.
// Depends on dpau_pkg and dpau_pulse_channel.
//
// Usage:
//   Input stream s_axis: one item per bus event. tuser carries the action
//   (tick, register write, status read); tdata carries the register offset
//   and the write byte. Output stream m_axis: one item per input item with
//   both pulse levels, the PCM level, the 16-bit mix and the status bits.
//   The channel state is updated at the edge where an item is accepted; the
//   levels after that item are captured in a stage register, and the mix
//   multiply-add then fills the output register from it. Throughput is one
//   item per cycle while the receiver takes the output, as both channels
//   update their whole state on every accepted item.
//   Reset clears all channel state, the PCM level, both dividers and the
//   pipeline. When the receiver stalls, the output register holds and the
//   stage register still takes one more item; after that s_axis_tready drops
//   until the output is taken.
module dual_pulse_audio_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [1:0]  s_axis_tuser,   // [1:0] action
  input  logic [15:0] s_axis_tdata,   // [4:0] reg_offset, [12:5] write_data, [15:13] zero
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [3:0] pulse_one_level, [7:4] pulse_two_level, [15:8] pcm_level,
  // [31:16] mixed_level, [33:32] read_data, [39:34] zero
  output logic [39:0] m_axis_tdata
);
  import dpau_pkg::*;

  logic         accept;
  dpau_action_t action;
  logic [4:0]   reg_offset;
  logic [7:0]   write_data;
  logic         is_tick, is_write, is_read;

  logic [12:0]  quarter_div, quarter_div_next;
  logic [13:0]  half_div, half_div_next;
  logic         env_clk, len_clk;
  logic [7:0]   pcm, pcm_next;

  dpau_ch_ctl_t ch_ctl [2];
  logic [3:0]   ch_level [2];
  logic         ch_len_active [2];
  logic [1:0]   status;

  // Stage register
  logic         st_valid;
  logic [3:0]   st_p1, st_p2;
  logic [7:0]   st_pcm;
  logic [1:0]   st_status;

  // Output register
  logic         out_valid;
  logic [3:0]   out_p1, out_p2;
  logic [7:0]   out_pcm;
  logic [15:0]  out_mix;
  logic [1:0]   out_status;

  logic         out_load;
  logic [4:0]   pulse_sum;
  logic [15:0]  mix_next;

  assign out_load      = !out_valid || m_axis_tready;
  assign s_axis_tready = !st_valid || out_load;
  assign accept        = s_axis_tvalid && s_axis_tready;

  assign action     = dpau_action_t'(s_axis_tuser);
  assign reg_offset = s_axis_tdata[4:0];
  assign write_data = s_axis_tdata[12:5];
  assign is_tick    = accept && action == ACT_TICK;
  assign is_write   = accept && action == ACT_WRITE;
  assign is_read    = accept && action == ACT_READ;

  // Wrapping frame dividers
  always_comb begin
    quarter_div_next = quarter_div;
    half_div_next    = half_div;
    env_clk          = 1'b0;
    len_clk          = 1'b0;
    if (is_tick) begin
      if (quarter_div == QUARTER_LAST) begin
        quarter_div_next = '0;
        env_clk          = 1'b1;
      end else begin
        quarter_div_next = quarter_div + 13'd1;
      end
      if (half_div == HALF_LAST) begin
        half_div_next = '0;
        len_clk       = 1'b1;
      end else begin
        half_div_next = half_div + 14'd1;
      end
    end
  end

  assign pcm_next = (is_write && reg_offset == OFF_PCM) ? write_data : pcm;

  for (genvar c = 0; c < 2; c++) begin : g_ch
    logic ch_write;
    assign ch_write = is_write && !reg_offset[4] && !reg_offset[3] &&
                      reg_offset[2] == 1'(c);

    assign ch_ctl[c].tick       = is_tick;
    assign ch_ctl[c].env_clk    = env_clk;
    assign ch_ctl[c].len_clk    = len_clk;
    assign ch_ctl[c].wr_ctrl    = ch_write && reg_offset[1:0] == OFF_CH_CTRL;
    assign ch_ctl[c].wr_lo      = ch_write && reg_offset[1:0] == OFF_CH_LO;
    assign ch_ctl[c].wr_hi      = ch_write && reg_offset[1:0] == OFF_CH_HI;
    assign ch_ctl[c].wr_enable  = is_write && reg_offset == OFF_STATUS;
    assign ch_ctl[c].enable_bit = write_data[c];

    dpau_pulse_channel u_ch (
      .clk        (clk),
      .rst        (rst),
      .ctl        (ch_ctl[c]),
      .wdata      (write_data),
      .level      (ch_level[c]),
      .len_active (ch_len_active[c])
    );
  end

  assign status = (is_read && reg_offset == OFF_STATUS) ?
                  {ch_len_active[1], ch_len_active[0]} : 2'b00;

  always_ff @(posedge clk) begin
    if (rst) begin
      quarter_div <= '0;
      half_div    <= '0;
      pcm         <= '0;
    end else begin
      quarter_div <= quarter_div_next;
      half_div    <= half_div_next;
      pcm         <= pcm_next;
    end
  end

  // Stage register: levels after the item
  always_ff @(posedge clk) begin
    if (rst) begin
      st_valid <= 1'b0;
    end else if (s_axis_tready) begin
      st_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      st_p1     <= ch_level[0];
      st_p2     <= ch_level[1];
      st_pcm    <= pcm_next;
      st_status <= status;
    end
  end

  assign pulse_sum = {1'b0, st_p1} + {1'b0, st_p2};
  assign mix_next  = 16'({11'd0, pulse_sum} * MIX_PULSE) +
                     16'({8'd0, st_pcm} * MIX_PCM);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= st_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load && st_valid) begin
      out_p1     <= st_p1;
      out_p2     <= st_p2;
      out_pcm    <= st_pcm;
      out_mix    <= mix_next;
      out_status <= st_status;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {6'd0, out_status, out_mix, out_pcm, out_p2, out_p1};

endmodule

// ===== design/dpau_checker.sv =====
// Port-level checks for the dual pulse audio unit, bound to the top level.
// Depends on dpau_pkg and dual_pulse_audio_unit.
module dpau_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [39:0] m_axis_tdata
);
  import dpau_pkg::*;

  logic [4:0]  chk_sum;
  logic [15:0] chk_mix;

  assign chk_sum = {1'b0, m_axis_tdata[3:0]} + {1'b0, m_axis_tdata[7:4]};
  assign chk_mix = 16'({11'd0, chk_sum} * MIX_PULSE) +
                   16'({8'd0, m_axis_tdata[15:8]} * MIX_PCM);

  // Nothing leaves the block right after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("output valid right after reset");

  // Stalled item holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled output item changed");

  // Mix agrees with the levels it carries
  a_mix: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tdata[31:16] == chk_mix)
    else $error("mixed level does not match channel and pcm levels");

  // Accepted item reaches the output when not stalled
  a_latency: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready ##1 m_axis_tready |=> m_axis_tvalid)
    else $error("accepted item did not reach the output");

  // Reserved bits stay clear
  a_pad: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tdata[39:34] == 6'd0)
    else $error("output padding bits set");

endmodule

bind dual_pulse_audio_unit dpau_checker u_dpau_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

// ===== dv/tb_top.sv =====
// Self-checking testbench for dual_pulse_audio_unit: drives bus items over s_axis,
// predicts channel levels, PCM level, mix and status per item, and checks m_axis.
// Depends on dpau_pkg and the dual_pulse_audio_unit RTL.
`timescale 1ns / 100ps

module tb_top;
  import dpau_pkg::*;

  localparam int ENV_TICKS = 7457;
  localparam int LEN_TICKS = 14913;
  localparam int PULSE_WEIGHT = 493;
  localparam int PCM_WEIGHT = 131;

  localparam logic [4:0] P1_CTRL = {3'b000, OFF_CH_CTRL};
  localparam logic [4:0] P1_LO   = {3'b000, OFF_CH_LO};
  localparam logic [4:0] P1_HI   = {3'b000, OFF_CH_HI};
  localparam logic [4:0] P2_CTRL = {3'b001, OFF_CH_CTRL};
  localparam logic [4:0] P2_LO   = {3'b001, OFF_CH_LO};
  localparam logic [4:0] P2_HI   = {3'b001, OFF_CH_HI};
  localparam logic [4:0] BUS_REGS [8] = '{P1_CTRL, P1_LO, P1_HI, P2_CTRL, P2_LO, P2_HI,
                                          OFF_PCM, OFF_STATUS};
  localparam logic [4:0] UNUSED_REGS [4] = '{5'h01, 5'h05, 5'h08, 5'h1F};

  localparam logic [7:0] DUTY_WAVE [4] = '{8'h02, 8'h06, 8'h1E, 8'hF9};
  localparam logic [7:0] NOTE_LENGTHS [32] = '{
    8'd10,  8'd254, 8'd20, 8'd2,  8'd40, 8'd4,  8'd80, 8'd6,
    8'd160, 8'd8,   8'd60, 8'd10, 8'd14, 8'd12, 8'd26, 8'd14,
    8'd12,  8'd16,  8'd24, 8'd18, 8'd48, 8'd20, 8'd96, 8'd22,
    8'd192, 8'd24,  8'd72, 8'd26, 8'd16, 8'd28, 8'd32, 8'd30
  };

  // Same layout as m_axis_tdata[33:0]
  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] mix;
    logic [7:0]  pcm;
    logic [3:0]  p2;
    logic [3:0]  p1;
  } audio_out_t;

  logic        clk;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [1:0]  s_axis_tuser = ACT_TICK;   // [1:0] action
  logic [15:0] s_axis_tdata = '0;         // [4:0] reg_offset, [12:5] write_data, [15:13] zero
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  // [3:0] pulse_one_level, [7:4] pulse_two_level, [15:8] pcm_level,
  // [31:16] mixed_level, [33:32] read_data, [39:34] zero
  logic [39:0] m_axis_tdata;

  // Channel state mirror
  logic [11:0] timer_cnt [2] = '{12'd0, 12'd0};
  logic [10:0] period [2] = '{11'd0, 11'd0};
  logic [2:0]  step_pos [2] = '{3'd0, 3'd0};
  logic [1:0]  duty_sel [2] = '{2'd0, 2'd0};
  logic        halt [2] = '{1'b0, 1'b0};
  logic        const_vol [2] = '{1'b0, 1'b0};
  logic [3:0]  vol_rate [2] = '{4'd0, 4'd0};
  logic        env_start [2] = '{1'b0, 1'b0};
  logic [3:0]  env_level [2] = '{4'd0, 4'd0};
  logic [3:0]  env_count [2] = '{4'd0, 4'd0};
  logic [7:0]  note_len [2] = '{8'd0, 8'd0};
  logic        ch_on [2] = '{1'b0, 1'b0};
  logic [7:0]  pcm_level = '0;
  logic [12:0] env_div = '0;
  logic [13:0] len_div = '0;

  audio_out_t pending_levels [$];
  audio_out_t want;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int mismatch_count = 0;
  int results_checked = 0;
  int ticks_seen = 0;
  int writes_seen = 0;
  int reads_seen = 0;
  int env_clocks = 0;
  int len_clocks = 0;

  dual_pulse_audio_unit i_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #(10_000_000);
    $display("tb_top failed");
    $finish;
  end

  // Apply one bus item to the mirror and queue the levels it leaves behind
  function automatic void apply_bus_item(input logic [1:0] act, input logic [4:0] off,
                                         input logic [7:0] d);
    int c;
    int mix_sum;
    logic [3:0] lvl [2];
    audio_out_t item_out;
    item_out.status = '0;
    case (act)
      ACT_TICK: begin
        ticks_seen++;
        for (c = 0; c < 2; c++) begin
          if (timer_cnt[c] == '0) begin
            timer_cnt[c] = {period[c], 1'b1};
            step_pos[c] = step_pos[c] + 3'd1;
          end else begin
            timer_cnt[c] = timer_cnt[c] - 12'd1;
          end
        end
        if (env_div == ENV_TICKS - 1) begin
          env_div = '0;
          env_clocks++;
          for (c = 0; c < 2; c++) begin
            if (env_start[c]) begin
              env_start[c] = 1'b0;
              env_level[c] = 4'd15;
              env_count[c] = vol_rate[c];
            end else if (env_count[c] == '0) begin
              env_count[c] = vol_rate[c];
              if (env_level[c] != '0) env_level[c] = env_level[c] - 4'd1;
              else if (halt[c]) env_level[c] = 4'd15;
            end else begin
              env_count[c] = env_count[c] - 4'd1;
            end
          end
        end else begin
          env_div = env_div + 13'd1;
        end
        if (len_div == LEN_TICKS - 1) begin
          len_div = '0;
          len_clocks++;
          for (c = 0; c < 2; c++)
            if (note_len[c] != '0 && !halt[c]) note_len[c] = note_len[c] - 8'd1;
        end else begin
          len_div = len_div + 14'd1;
        end
      end
      ACT_WRITE: begin
        writes_seen++;
        if (off < 5'd8) begin
          c = off[2];
          case (off[1:0])
            OFF_CH_CTRL: begin
              duty_sel[c] = d[7:6];
              halt[c] = d[5];
              const_vol[c] = d[4];
              vol_rate[c] = d[3:0];
            end
            OFF_CH_LO: period[c][7:0] = d;
            OFF_CH_HI: begin
              period[c][10:8] = d[2:0];
              if (ch_on[c]) note_len[c] = NOTE_LENGTHS[d[7:3]];
              step_pos[c] = '0;
              env_start[c] = 1'b1;
            end
            default: ;
          endcase
        end else if (off == OFF_PCM) begin
          pcm_level = d;
        end else if (off == OFF_STATUS) begin
          ch_on[0] = d[0];
          ch_on[1] = d[1];
          if (!d[0]) note_len[0] = '0;
          if (!d[1]) note_len[1] = '0;
        end
      end
      ACT_READ: begin
        reads_seen++;
        if (off == OFF_STATUS) item_out.status = {note_len[1] != '0, note_len[0] != '0};
      end
      default: ;
    endcase
    for (c = 0; c < 2; c++) begin
      if (!ch_on[c] || note_len[c] == '0 || period[c] < 11'd8)
        lvl[c] = '0;
      else if (!DUTY_WAVE[duty_sel[c]][step_pos[c]])
        lvl[c] = '0;
      else
        lvl[c] = const_vol[c] ? vol_rate[c] : env_level[c];
    end
    mix_sum = (int'(lvl[0]) + int'(lvl[1])) * PULSE_WEIGHT + int'(pcm_level) * PCM_WEIGHT;
    item_out.p1 = lvl[0];
    item_out.p2 = lvl[1];
    item_out.pcm = pcm_level;
    item_out.mix = mix_sum[15:0];
    pending_levels.push_back(item_out);
  endfunction

  task automatic flag_error(input string msg);
    mismatch_count++;
    if (mismatch_count <= 10) $display("%0t ERROR %s", $time, msg);
  endtask

  always @(posedge clk) begin
    m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Predict on input acceptance first, so the queue is current before the pop
  always @(posedge clk) begin
    if (!rst) begin
      if (s_axis_tvalid && s_axis_tready)
        apply_bus_item(s_axis_tuser, s_axis_tdata[4:0], s_axis_tdata[12:5]);
      if (m_axis_tvalid && m_axis_tready) begin
        if (pending_levels.size() == 0) begin
          flag_error($sformatf("output with nothing pending: %h", m_axis_tdata));
        end else begin
          want = pending_levels.pop_front();
          results_checked++;
          if (m_axis_tdata[33:0] !== want)
            flag_error($sformatf({"result %0d: expected p1=%0d p2=%0d pcm=%0d mix=%0d st=%0d,",
                                  " got p1=%0d p2=%0d pcm=%0d mix=%0d st=%0d"},
                                 results_checked, want.p1, want.p2, want.pcm, want.mix,
                                 want.status, m_axis_tdata[3:0], m_axis_tdata[7:4],
                                 m_axis_tdata[15:8], m_axis_tdata[31:16],
                                 m_axis_tdata[33:32]));
        end
      end
    end
  end

  task automatic send_item(input dpau_action_t act, input logic [4:0] off,
                           input logic [7:0] d);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= act;
    s_axis_tdata <= {3'b000, d, off};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
  endtask

  // Hold the input until every pending result is out
  task automatic wait_for_results();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_levels.size() != 0) @(posedge clk);
  endtask

  task automatic test_reset_values();
    send_item(ACT_TICK, 5'h1F, 8'hFF);
    send_item(ACT_READ, OFF_STATUS, 8'hFF);
    send_item(ACT_NONE, OFF_STATUS, 8'hFF);
    send_item(ACT_READ, OFF_PCM, 8'h00);
  endtask

  task automatic test_register_writes();
    int i;
    // channel one is still disabled: no length load
    send_item(ACT_WRITE, P1_HI, 8'hF8);
    send_item(ACT_READ, OFF_STATUS, 8'h00);
    send_item(ACT_WRITE, OFF_STATUS, 8'hFF);
    send_item(ACT_WRITE, P1_CTRL, 8'hFF);
    send_item(ACT_WRITE, P1_LO, 8'hFF);
    send_item(ACT_WRITE, P1_HI, 8'hFF);
    send_item(ACT_WRITE, P2_CTRL, 8'h3F);
    send_item(ACT_WRITE, P2_LO, 8'h07);
    send_item(ACT_WRITE, P2_HI, 8'h08);
    send_item(ACT_READ, OFF_STATUS, 8'h00);
    send_item(ACT_READ, 5'h14, 8'h00);
    send_item(ACT_WRITE, OFF_PCM, 8'hFF);
    for (i = 0; i < 3; i++) send_item(ACT_TICK, 5'h00, 8'h00);
    send_item(ACT_WRITE, P2_LO, 8'h08);
    send_item(ACT_TICK, 5'h00, 8'h00);
    for (i = 0; i < 4; i++) send_item(ACT_WRITE, UNUSED_REGS[2'(i)], 8'h00);
    send_item(ACT_NONE, OFF_STATUS, 8'h00);
    send_item(ACT_WRITE, OFF_STATUS, 8'h02);
    send_item(ACT_READ, OFF_STATUS, 8'hFF);
    send_item(ACT_WRITE, OFF_PCM, 8'h00);
  endtask

  // Mostly ticks and well-formed register writes with short periods, plus noise
  task automatic test_random_traffic(input int count);
    int n;
    int pick;
    dpau_action_t act;
    logic [4:0] off;
    logic [7:0] d;
    for (n = 0; n < count; n++) begin
      pick = $urandom_range(99);
      off = 5'($urandom);
      d = 8'($urandom);
      if (pick < 68) begin
        act = ACT_TICK;
      end else if (pick < 92) begin
        act = ACT_WRITE;
        if ($urandom_range(9) < 8) off = BUS_REGS[3'($urandom_range(7))];
        if (off < 5'd8 && off[1:0] == OFF_CH_HI && $urandom_range(3) != 0) d[2:0] = '0;
        if (off < 5'd8 && off[1:0] == OFF_CH_LO && $urandom_range(2) != 0)
          d = 8'($urandom_range(48, 8));
        if (off == OFF_STATUS && $urandom_range(4) != 0) d[1:0] = 2'b11;
      end else if (pick < 98) begin
        act = ACT_READ;
        if ($urandom_range(3) != 0) off = OFF_STATUS;
      end else begin
        act = ACT_NONE;
      end
      send_item(act, off, d);
    end
  endtask

  // Tick runs on fixed channel setups, with status reads in between
  task automatic test_long_ticks(input int count);
    int n;
    send_item(ACT_WRITE, OFF_STATUS, 8'h03);
    send_item(ACT_WRITE, P1_CTRL, 8'hA1);
    send_item(ACT_WRITE, P1_LO, 8'h08);
    send_item(ACT_WRITE, P1_HI, 8'h08);
    send_item(ACT_WRITE, P2_CTRL, 8'h40);
    send_item(ACT_WRITE, P2_LO, 8'h0C);
    send_item(ACT_WRITE, P2_HI, 8'h28);
    for (n = 1; n <= count; n++) begin
      send_item(ACT_TICK, 5'h00, 8'h00);
      if (n % 16 == 0) send_item(ACT_READ, OFF_STATUS, 8'h00);
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    send_idle_pct = 31;
    recv_stall_pct = 59;
    test_reset_values();
    test_register_writes();
    wait_for_results();
    test_random_traffic(420);
    wait_for_results();
    test_long_ticks(60);
    wait_for_results();

    send_idle_pct = 59;
    recv_stall_pct = 31;
    test_random_traffic(420);
    wait_for_results();

    send_idle_pct = 0;
    recv_stall_pct = 0;
    test_random_traffic(420);
    wait_for_results();
    test_long_ticks(60);
    wait_for_results();

    repeat (8) @(posedge clk);
    if (pending_levels.size() != 0)
      flag_error($sformatf("%0d results never arrived", pending_levels.size()));
    $display("Covered %0d ticks, %0d writes, %0d reads; %0d envelope and %0d length clocks.",
             ticks_seen, writes_seen, reads_seen, env_clocks, len_clocks);
    $display("Checked %0d results, %0d mismatches.", results_checked, mismatch_count);
    if (mismatch_count == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule
